### design/crc16_packet_deframer_assert.svh
// crc16_packet_deframer_assert.svh: assertion macros shared by the deframer rtl
// no dependencies; included by the modules that carry checks
`ifndef CRC16_PACKET_DEFRAMER_ASSERT_SVH
`define CRC16_PACKET_DEFRAMER_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define CPD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// when ante holds, cons must hold in the same cycle
`define CPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// when ante holds, cons must hold in the next cycle
`define CPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cpd_pkg.sv
// cpd_pkg: types, constants and the crc byte step for the packet deframer
// no dependencies
package cpd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [15:0] crc_t;

  localparam byte_t SYNC_BYTE = 8'hA5;
  localparam crc_t CRC_POLY = 16'hA001;
  localparam crc_t BYTE_MASK = 16'h00FF;
  localparam int HDR_LEN = 5;

  // bytes_seen never exceeds 65539
  localparam int SEEN_W = 17;
  typedef logic [SEEN_W-1:0] seen_t;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int QA_W = $clog2(Q_DEPTH);
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  // one byte headed for the crc engine, tagged with its place in the frame
  typedef struct packed {
    byte_t data;
    logic  sof;
    logic  eof;
    byte_t ftype;
  } qent_t;

  // crc-16/arc over one byte, reflected form
  function automatic crc_t crc_step(input crc_t crc, input byte_t b);
    crc_t v;
    v = (crc ^ {8'h00, b}) & BYTE_MASK;
    for (int i = 0; i < 8; i++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return (crc >> 8) ^ v;
  endfunction

endpackage

### design/cpd_in_if.sv
// cpd_in_if: received byte channel, valid/ready with one byte per request
// depends on cpd_pkg
interface cpd_in_if;
  logic valid;
  logic ready;
  cpd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### design/cpd_out_if.sv
// cpd_out_if: frame result channel, valid/ready with status and type
// depends on cpd_pkg
interface cpd_out_if;
  logic valid;
  logic ready;
  logic frame_status;
  cpd_pkg::byte_t frame_type;

  modport source (output valid, output frame_status, output frame_type, input ready);
  modport sink (input valid, input frame_status, input frame_type, output ready);
endinterface

### design/crc16_packet_deframer.sv
// crc16_packet_deframer: crc-16/arc checked packet deframer, top level
// depends on cpd_pkg, cpd_in_if, cpd_out_if, cpd_front, cpd_queue, cpd_back
//
// usage:
//   in_ch carries one received byte per request (rx_byte). frames look like
//   0xa5, second sync byte (not checked), type, count high, count low, then
//   count bytes whose last two are the little-endian crc-16/arc of the frame.
//   bytes other than 0xa5 between frames are taken and dropped.
//   out_ch carries one request per finished frame: frame_status 0 with the
//   type byte when the crc residue is zero, else frame_status 1 and type 0.
//   payload is not forwarded.
// timing:
//   one byte per cycle sustained while the byte queue has room; the crc step is one
//   table-free byte update in the back end. a result is registered on out_ch after the
//   frame's last byte has passed the 4-entry byte queue, later if the queue is backed up.
// reset and stall:
//   rst_n (synchronous, active low) empties the queue, drops any partial
//   frame and clears the result register. a stalled out_ch holds its result;
//   the back end keeps crunching bytes until it reaches the next frame end,
//   and in_ch drops ready only once the byte queue fills.

module crc16_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  cpd_in_if.sink     in_ch,
  cpd_out_if.source  out_ch
);
  import cpd_pkg::*;

  // front to queue
  logic   push;
  qent_t  push_ent;
  logic   q_full;

  // queue to back
  logic   q_valid;
  qent_t  head_ent;
  logic   pop;

  // frame position tracking and sync hunt
  cpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  // decouples byte intake from the result side
  cpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_ent (head_ent)
  );

  // running crc and result register
  cpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head_ent (head_ent),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### design/cpd_front.sv
// cpd_front: frame tracker, drops idle bytes and tags frame bytes for the queue
// depends on cpd_pkg, cpd_in_if and the assertion header
`include "crc16_packet_deframer_assert.svh"

module cpd_front (
  input  logic            clk,
  input  logic            rst_n,
  cpd_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output cpd_pkg::qent_t  push_ent
);
  import cpd_pkg::*;

  localparam seen_t POS_SOF    = seen_t'(0);
  localparam seen_t POS_TYPE   = seen_t'(2);
  localparam seen_t POS_CNT_HI = seen_t'(3);
  localparam seen_t POS_CNT_LO = seen_t'(4);

  seen_t          seen_r, seen_nxt;
  logic [15:0]    cnt_r, cnt_nxt;
  byte_t          type_r, type_nxt;

  logic           accept;
  logic           drop;
  logic           last;
  logic [15:0]    cnt_cur;
  byte_t          type_cur;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign drop = (seen_r == POS_SOF) && (in_ch.rx_byte != SYNC_BYTE);

  always_comb begin
    cnt_cur = cnt_r;
    type_cur = type_r;
    case (seen_r)
      POS_TYPE:   type_cur = in_ch.rx_byte;
      POS_CNT_HI: cnt_cur = {in_ch.rx_byte, 8'h00};
      POS_CNT_LO: cnt_cur = {cnt_r[15:8], in_ch.rx_byte};
      default:    cnt_cur = cnt_r;
    endcase
  end

  // frame ends once seen + 1 reaches count + header length
  assign last = (seen_r >= POS_CNT_LO) &&
                (seen_r >= (seen_t'(cnt_cur) + seen_t'(HDR_LEN - 1)));

  assign push = accept && !drop;
  assign push_ent = '{data: in_ch.rx_byte, sof: (seen_r == POS_SOF), eof: last,
                      ftype: type_cur};

  always_comb begin
    seen_nxt = seen_r;
    cnt_nxt = cnt_r;
    type_nxt = type_r;
    if (push) begin
      if (last) begin
        seen_nxt = '0;
        cnt_nxt = '0;
        type_nxt = '0;
      end else begin
        seen_nxt = seen_r + seen_t'(1);
        cnt_nxt = cnt_cur;
        type_nxt = type_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      cnt_r <= '0;
      type_r <= '0;
    end else begin
      seen_r <= seen_nxt;
      cnt_r <= cnt_nxt;
      type_r <= type_nxt;
    end
  end

  `CPD_ASSERT_ALWAYS(a_seen_bound, clk, rst_n, seen_r <= seen_t'(65539), "frame position overrun")
  `CPD_ASSERT_NXT(a_last_resets, clk, rst_n, push && last, seen_r == POS_SOF, "no resync after frame end")

endmodule

### design/cpd_queue.sv
// cpd_queue: short fifo of tagged frame bytes between front and back
// depends on cpd_pkg and the assertion header
`include "crc16_packet_deframer_assert.svh"

module cpd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  cpd_pkg::qent_t  push_ent,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output cpd_pkg::qent_t  head_ent
);
  import cpd_pkg::*;

  qent_t              mem_r [Q_DEPTH];
  logic [QA_W-1:0]    wr_r, wr_nxt;
  logic [QA_W-1:0]    rd_r, rd_nxt;
  logic [QC_W-1:0]    cnt_r, cnt_nxt;

  assign full = (cnt_r == QC_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head_ent = mem_r[rd_r];

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QA_W'(Q_DEPTH - 1)) ? '0 : wr_r + QA_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == QA_W'(Q_DEPTH - 1)) ? '0 : rd_r + QA_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QC_W'(1);
      2'b01:   cnt_nxt = cnt_r - QC_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

  `CPD_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
  `CPD_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, q_valid, "pop from empty queue")

endmodule

### design/cpd_back.sv
// cpd_back: running crc over queued frame bytes and the result register
// depends on cpd_pkg, cpd_out_if and the assertion header
`include "crc16_packet_deframer_assert.svh"

module cpd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  cpd_pkg::qent_t  head_ent,
  output logic            pop,
  cpd_out_if.source       out_ch
);
  import cpd_pkg::*;

  crc_t   crc_r, crc_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   status_r;
  byte_t  type_r;
  logic   out_free;
  crc_t   crc_base;

  assign out_free = !out_valid_r || out_ch.ready;
  // only a frame's last byte needs room in the result register
  assign pop = q_valid && (!head_ent.eof || out_free);

  assign crc_base = head_ent.sof ? '0 : crc_r;
  assign crc_nxt = pop ? crc_step(crc_base, head_ent.data) : crc_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (pop && head_ent.eof) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_ent.eof) begin
      status_r <= (crc_nxt != '0);
      type_r <= (crc_nxt == '0) ? head_ent.ftype : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.frame_type = type_r;

  `CPD_ASSERT_IMP(a_eof_room, clk, rst_n, pop && head_ent.eof, out_free, "result overwritten")
  `CPD_ASSERT_IMP(a_err_type_zero, clk, rst_n, out_valid_r && status_r, type_r == '0, "type on crc error")

endmodule

### dv/tb.sv
// tb: self-checking testbench for crc16_packet_deframer, streams framed and stray bytes
// depends on cpd_pkg, cpd_in_if, cpd_out_if and the deframer rtl
module tb;
  import cpd_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 4;
  // bytes can sit in the 4-entry queue behind a finished frame, plus the result register
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int TIMEOUT_TU = 12_000_000;
  // count with a nonzero high byte
  localparam int LONG_COUNT = 300;

  // frame_status codes
  localparam logic ST_GOOD = 1'b0;
  localparam logic ST_CRC_ERR = 1'b1;

  // byte positions inside the frame header
  localparam int POS_SYNC2 = 1;
  localparam int POS_TYPE = 2;
  localparam int POS_CNT_HI = 3;
  localparam int POS_CNT_LO = 4;

  typedef struct packed {
    logic  status;
    byte_t ftype;
  } frame_result_t;

  logic clk;
  logic rst_n;

  cpd_in_if in_ch();
  cpd_out_if out_ch();

  crc16_packet_deframer dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // expected frame results, oldest first
  frame_result_t expected_frames[$];

  // shadow of the deframer state, updated on every accepted byte
  seen_t frame_pos;
  crc_t  crc_acc;
  crc_t  frame_len;
  byte_t type_latched;

  // bytes of the frame being built for sending
  byte_t frame_bytes[$];

  // idling knobs, percent per cycle
  int send_idle_pct;
  int recv_stall_pct;
  // cycles left in a forced receiver hold-off
  int hold_left;

  int mismatches;
  int bytes_accepted;
  int frames_good;
  int frames_bad;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // watchdog
  initial begin
    #(TIMEOUT_TU);
    $display("timeout with %0d frame results still pending", expected_frames.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // reflected crc-16/arc, one input bit at a time
  function automatic crc_t crc_add_byte(input crc_t c, input byte_t b);
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic crc_t crc_of_frame(input int upto);
    crc_t c;
    c = '0;
    for (int i = 0; i < upto; i++) begin
      c = crc_add_byte(c, frame_bytes[i]);
    end
    return c;
  endfunction

  function automatic void clear_shadow();
    frame_pos = '0;
    crc_acc = '0;
    frame_len = '0;
    type_latched = '0;
  endfunction

  // predicts what one accepted byte does to the frame in progress
  function automatic void track_byte(input byte_t b);
    frame_result_t r;
    // stray byte between frames is dropped without a trace
    if (frame_pos == 0 && b != SYNC_BYTE) begin
      return;
    end
    crc_acc = crc_add_byte(crc_acc, b);
    case (frame_pos)
      POS_TYPE:   type_latched = b;
      POS_CNT_HI: frame_len[15:8] = b;
      POS_CNT_LO: frame_len[7:0] = b;
      default: ;
    endcase
    frame_pos = frame_pos + 1'b1;
    // frame ends after header plus count bytes, counts of 0 and 1 included
    if (frame_pos >= HDR_LEN && frame_pos >= frame_len + HDR_LEN) begin
      if (crc_acc == '0) begin
        r.status = ST_GOOD;
        r.ftype = type_latched;
      end else begin
        r.status = ST_CRC_ERR;
        r.ftype = '0;
      end
      expected_frames.push_back(r);
      clear_shadow();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // monitor: input requests feed the predictor, output requests are checked
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n) begin
      // input side first so a same-edge result would still find its expectation
      if (in_ch.valid && in_ch.ready) begin
        bytes_accepted++;
        track_byte(in_ch.rx_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.frame_status;
        got.ftype = out_ch.frame_type;
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d type 0x%02h",
                                    got.status, got.ftype));
        end else begin
          want = expected_frames.pop_front();
          if (got.status != want.status) begin
            report_mismatch($sformatf("frame_status got %0d want %0d",
                                      got.status, want.status));
          end
          if (got.ftype != want.ftype) begin
            report_mismatch($sformatf("frame_type got 0x%02h want 0x%02h",
                                      got.ftype, want.ftype));
          end
          if (want.status == ST_GOOD) begin
            frames_good++;
          end else begin
            frames_bad++;
          end
        end
      end
    end
  end

  // receiver: random stalls, or a forced hold-off counted down here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offers one byte, with random idle cycles ahead of it, until it is taken
  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
  endtask

  // builds a frame with a valid crc, optionally breaks one bit, then sends it
  task automatic send_frame(input byte_t sync2, input byte_t ftype, input int count,
                            input bit corrupt);
    int n_free;
    int pick;
    int idx;
    crc_t c;
    frame_bytes.delete();
    frame_bytes.push_back(SYNC_BYTE);
    frame_bytes.push_back(sync2);
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(byte_t'(count >> 8));
    frame_bytes.push_back(byte_t'(count));
    if (count >= 2) begin
      for (int i = 0; i < count - 2; i++) begin
        frame_bytes.push_back(byte_t'($urandom));
      end
      c = crc_of_frame(frame_bytes.size());
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
    end else begin
      if (count == 1) begin
        frame_bytes.push_back(byte_t'($urandom));
      end
      // no room for crc bytes: pick sync2 and type so the residue comes out zero
      for (int st = 0; st < 65536; st++) begin
        frame_bytes[POS_SYNC2] = byte_t'(st >> 8);
        frame_bytes[POS_TYPE] = byte_t'(st);
        if (crc_of_frame(frame_bytes.size()) == '0) begin
          break;
        end
      end
    end
    if (corrupt) begin
      // any byte but the leading sync and the count bytes, so the length holds
      n_free = frame_bytes.size() - 3;
      pick = $urandom_range(n_free - 1);
      idx = (pick < 2) ? pick + POS_SYNC2 : pick + 3;
      frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
    end
  endtask

  // sender pause until every pending result is back, then let the queue settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    // let the monitor see the last accepted byte first
    @(posedge clk);
    while (expected_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stray bytes, zero and one counts, crc error, byte extremes
  task automatic test_directed_frames();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hA4);
    send_frame(8'h00, 8'h00, 0, 1'b0);
    send_frame(8'h00, 8'h00, 0, 1'b1);
    send_frame(8'h00, 8'h00, 1, 1'b0);
    send_frame(8'h00, 8'hFF, 2, 1'b0);
    wait_drained();
  endtask

  // receiver holds off long enough that the byte queue fills and input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left <= HOLD_CYCLES;
    for (int f = 0; f < 6; f++) begin
      send_frame(byte_t'($urandom), byte_t'($urandom), $urandom_range(2, 4),
                 ($urandom_range(3) == 0));
    end
    wait_drained();
  endtask

  // mostly well-formed frames with random content, some broken ones, some stray bytes
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int item_goal);
    int items;
    int roll;
    int count;
    byte_t b;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    items = 0;
    while (items < item_goal) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        repeat ($urandom_range(1, 3)) begin
          do begin
            b = byte_t'($urandom);
          end while (b == SYNC_BYTE);
          send_byte(b);
        end
      end else begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          count = $urandom_range(1);
        end else if (roll < 88) begin
          count = $urandom_range(2, 16);
        end else begin
          count = $urandom_range(17, 200);
        end
        send_frame(byte_t'($urandom), byte_t'($urandom), count, ($urandom_range(99) < 20));
        items += count + HDR_LEN;
      end
    end
    wait_drained();
  endtask

  // count above 255 so the high count byte matters
  task automatic test_long_frame();
    send_idle_pct = 0;
    recv_stall_pct = 61;
    send_frame(byte_t'($urandom), byte_t'($urandom), LONG_COUNT, 1'b0);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    mismatches = 0;
    bytes_accepted = 0;
    frames_good = 0;
    frames_bad = 0;
    clear_shadow();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_output_backpressure();
    test_random_traffic(0, 0, 215);
    test_random_traffic(61, 0, 215);
    test_random_traffic(0, 61, 215);
    test_random_traffic(30, 30, 215);
    test_long_frame();

    $display("covered %0d accepted bytes: %0d good frames and %0d crc errors checked",
             bytes_accepted, frames_good, frames_bad);
    $display("stray bytes, counts 0/1, a count of %0d, output hold-off and four idling mixes",
             LONG_COUNT);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### crc16_packet_deframer.f
+incdir+design
design/cpd_pkg.sv
design/cpd_in_if.sv
design/cpd_out_if.sv
design/cpd_front.sv
design/cpd_queue.sv
design/cpd_back.sv
design/crc16_packet_deframer.sv
dv/tb.sv
